[hw/rtl/bajc_pkg.sv]
// Shared types, register-file slot map and microprogram for the joint controller.
// No dependencies.
package bajc_pkg;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOV,
		OP_CLAMP
	} op_t;

	typedef logic [5:0] slot_t;

	// inputs, by field order
	localparam slot_t S_QS   = 6'd0;
	localparam slot_t S_VEL  = 6'd1;
	localparam slot_t S_T    = 6'd2;
	localparam slot_t S_DACC = 6'd3;
	localparam slot_t S_DVEL = 6'd4;
	localparam slot_t S_DPOS = 6'd5;
	// configuration registers at CFG_BASE + index
	localparam slot_t S_MG   = 6'd8;
	localparam slot_t S_BG   = 6'd9;
	localparam slot_t S_KG   = 6'd10;
	localparam slot_t S_LG   = 6'd11;
	localparam slot_t S_MX   = 6'd12;
	localparam slot_t S_BX   = 6'd13;
	localparam slot_t S_KX   = 6'd14;
	localparam slot_t S_TL   = 6'd15;
	// tick-to-tick state
	localparam slot_t S_PP   = 6'd16;
	localparam slot_t S_PV   = 6'd17;
	localparam slot_t S_IT   = 6'd18;
	localparam slot_t S_LMP  = 6'd19;
	localparam slot_t S_LT   = 6'd20;
	localparam slot_t S_ONE  = 6'd21;
	// temporaries
	localparam slot_t S_KHAT = 6'd24;
	localparam slot_t S_DENX = 6'd25;
	localparam slot_t S_S1   = 6'd26;
	localparam slot_t S_S2   = 6'd27;
	localparam slot_t S_US   = 6'd28;
	localparam slot_t S_QST  = 6'd29;
	localparam slot_t S_PHB  = 6'd30;
	localparam slot_t S_PHA  = 6'd31;
	localparam slot_t S_QSS  = 6'd32;
	localparam slot_t S_TST  = 6'd33;
	localparam slot_t S_TAU  = 6'd34;
	localparam slot_t S_QX   = 6'd35;
	localparam slot_t S_UX   = 6'd36;
	localparam slot_t S_AN   = 6'd37;
	localparam slot_t S_AX   = 6'd38;
	localparam slot_t S_PTAU = 6'd39;
	localparam slot_t S_X1   = 6'd40;
	localparam slot_t S_X2   = 6'd41;

	localparam logic [2:0] CFG_BASE_HI = 3'b001;
	localparam logic [2:0] IN_LAST     = 3'd5;
	localparam logic [5:0] PROG_LAST   = 6'd60;
	localparam logic [31:0] Q_ONE      = 32'h0001_0000;

	typedef struct packed {
		op_t   op;
		slot_t dst;
		slot_t a;
		slot_t b;
		logic  seed;
	} instr_t;

	typedef struct packed {
		logic  capture;
		logic  ld_en;
		logic [2:0] ld_k;
		logic  rd_en;
		slot_t rd_a;
		slot_t rd_b;
		logic  start;
		op_t   op;
		slot_t dst;
		logic  publish;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

	function automatic logic [31:0] rst_val(input slot_t s);
		logic [31:0] v;
		case (s)
			S_MG, S_BG, S_KG, S_LG, S_MX, S_BX, S_KX, S_ONE: v = Q_ONE;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic instr_t prog(input logic [5:0] pc);
		instr_t i;
		case (pc)
			6'd0:  i = '{OP_MOV, S_PP,   S_QS,   S_QS,   1'b1};
			6'd1:  i = '{OP_MOV, S_LMP,  S_QS,   S_QS,   1'b1};
			6'd2:  i = '{OP_MOV, S_PV,   S_VEL,  S_VEL,  1'b1};
			6'd3:  i = '{OP_DIV, S_X1,   S_BG,   S_T,    1'b0};
			6'd4:  i = '{OP_ADD, S_X1,   S_KG,   S_X1,   1'b0};
			6'd5:  i = '{OP_MUL, S_X2,   S_LG,   S_T,    1'b0};
			6'd6:  i = '{OP_ADD, S_KHAT, S_X1,   S_X2,   1'b0};
			6'd7:  i = '{OP_MUL, S_X1,   S_BX,   S_T,    1'b0};
			6'd8:  i = '{OP_ADD, S_DENX, S_MX,   S_X1,   1'b0};
			6'd9:  i = '{OP_MUL, S_X1,   S_KX,   S_T,    1'b0};
			6'd10: i = '{OP_MUL, S_X1,   S_X1,   S_T,    1'b0};
			6'd11: i = '{OP_DIV, S_X1,   S_X1,   S_DENX, 1'b0};
			6'd12: i = '{OP_ADD, S_S1,   S_ONE,  S_X1,   1'b0};
			6'd13: i = '{OP_DIV, S_X1,   S_MG,   S_T,    1'b0};
			6'd14: i = '{OP_DIV, S_X1,   S_X1,   S_T,    1'b0};
			6'd15: i = '{OP_ADD, S_S2,   S_KHAT, S_X1,   1'b0};
			6'd16: i = '{OP_MUL, S_X1,   S_MX,   S_DACC, 1'b0};
			6'd17: i = '{OP_MUL, S_X2,   S_BX,   S_DVEL, 1'b0};
			6'd18: i = '{OP_ADD, S_X1,   S_X1,   S_X2,   1'b0};
			6'd19: i = '{OP_MUL, S_X2,   S_KX,   S_DPOS, 1'b0};
			6'd20: i = '{OP_ADD, S_X1,   S_X1,   S_X2,   1'b0};
			6'd21: i = '{OP_MUL, S_X2,   S_MX,   S_PV,   1'b0};
			6'd22: i = '{OP_MUL, S_X1,   S_T,    S_X1,   1'b0};
			6'd23: i = '{OP_ADD, S_X1,   S_X2,   S_X1,   1'b0};
			6'd24: i = '{OP_DIV, S_US,   S_X1,   S_DENX, 1'b0};
			6'd25: i = '{OP_MUL, S_X1,   S_T,    S_US,   1'b0};
			6'd26: i = '{OP_ADD, S_QST,  S_PP,   S_X1,   1'b0};
			6'd27: i = '{OP_SUB, S_X1,   S_PP,   S_LMP,  1'b0};
			6'd28: i = '{OP_MUL, S_X1,   S_BG,   S_X1,   1'b0};
			6'd29: i = '{OP_DIV, S_X1,   S_X1,   S_T,    1'b0};
			6'd30: i = '{OP_MUL, S_X2,   S_LG,   S_IT,   1'b0};
			6'd31: i = '{OP_SUB, S_PHB,  S_X1,   S_X2,   1'b0};
			6'd32: i = '{OP_SUB, S_X1,   S_QS,   S_PP,   1'b0};
			6'd33: i = '{OP_MUL, S_X2,   S_T,    S_PV,   1'b0};
			6'd34: i = '{OP_SUB, S_X1,   S_X1,   S_X2,   1'b0};
			6'd35: i = '{OP_MUL, S_X1,   S_MG,   S_X1,   1'b0};
			6'd36: i = '{OP_DIV, S_X1,   S_X1,   S_T,    1'b0};
			6'd37: i = '{OP_DIV, S_PHA,  S_X1,   S_T,    1'b0};
			6'd38: i = '{OP_SUB, S_X1,   S_PHB,  S_PHA,  1'b0};
			6'd39: i = '{OP_DIV, S_X1,   S_X1,   S_S2,   1'b0};
			6'd40: i = '{OP_ADD, S_QSS,  S_QS,   S_X1,   1'b0};
			6'd41: i = '{OP_DIV, S_X1,   S_S2,   S_S1,   1'b0};
			6'd42: i = '{OP_MUL, S_X1,   S_X1,   S_QST,  1'b0};
			6'd43: i = '{OP_MUL, S_X2,   S_S2,   S_QSS,  1'b0};
			6'd44: i = '{OP_SUB, S_TST,  S_X1,   S_X2,   1'b0};
			6'd45: i = '{OP_CLAMP, S_TAU, S_TST, S_TL,   1'b0};
			6'd46: i = '{OP_DIV, S_X1,   S_TAU,  S_S2,   1'b0};
			6'd47: i = '{OP_ADD, S_QX,   S_QSS,  S_X1,   1'b0};
			6'd48: i = '{OP_SUB, S_X1,   S_QX,   S_PP,   1'b0};
			6'd49: i = '{OP_DIV, S_UX,   S_X1,   S_T,    1'b0};
			6'd50: i = '{OP_SUB, S_X1,   S_QX,   S_QS,   1'b0};
			6'd51: i = '{OP_MUL, S_X1,   S_T,    S_X1,   1'b0};
			6'd52: i = '{OP_ADD, S_AN,   S_IT,   S_X1,   1'b0};
			6'd53: i = '{OP_SUB, S_X1,   S_UX,   S_PV,   1'b0};
			6'd54: i = '{OP_DIV, S_AX,   S_X1,   S_T,    1'b0};
			6'd55: i = '{OP_MOV, S_PTAU, S_LT,   S_LT,   1'b0};
			6'd56: i = '{OP_MOV, S_PP,   S_QX,   S_QX,   1'b0};
			6'd57: i = '{OP_MOV, S_PV,   S_UX,   S_UX,   1'b0};
			6'd58: i = '{OP_MOV, S_LMP,  S_QS,   S_QS,   1'b0};
			6'd59: i = '{OP_MOV, S_IT,   S_AN,   S_AN,   1'b0};
			6'd60: i = '{OP_MOV, S_LT,   S_TAU,  S_TAU,  1'b0};
			default: i = '{OP_MOV, S_X1, S_X1,   S_X1,   1'b0};
		endcase
		return i;
	endfunction

endpackage

[hw/rtl/bounded_admittance_joint_control_top.sv]
// Proxy-based bounded admittance controller for one joint, signed Q16.16.
// A transaction runs a 61-step microprogram on one shared saturating unit after
// its six inputs are loaded. A division runs in the bit-serial divider unless
// its divisor is zero, which skips the divider and gives a saturated or zero
// result; the first tick also runs the steps that seed the proxy. The input is
// taken again as soon as the result is handed to the output register, which
// holds it until taken; a result still held there delays the hand-off.
// Configuration writes are taken only while no tick is in progress.
// Depends on bajc_pkg, bajc_ctrl, bajc_datapath, bajc_alu.
module bounded_admittance_joint_control_top
	import bajc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] measured_pos,
	input  logic [31:0] measured_vel,
	input  logic [15:0] step_period,
	input  logic [31:0] desired_acc,
	input  logic [31:0] desired_vel,
	input  logic [31:0] desired_pos,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] torque_now,
	output logic [31:0] torque_before,
	output logic [31:0] proxy_pos_out,
	output logic [31:0] proxy_vel_out,
	output logic [31:0] proxy_acc_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	bajc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.status    (status)
	);

	bajc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.measured_pos  (measured_pos),
		.measured_vel  (measured_vel),
		.step_period   (step_period),
		.desired_acc   (desired_acc),
		.desired_vel   (desired_vel),
		.desired_pos   (desired_pos),
		.torque_now    (torque_now),
		.torque_before (torque_before),
		.proxy_pos_out (proxy_pos_out),
		.proxy_vel_out (proxy_vel_out),
		.proxy_acc_out (proxy_acc_out)
	);

endmodule

[hw/rtl/bajc_alu.sv]
// Saturating Q16.16 arithmetic unit: add, subtract, move, clamp, multiply with a
// registered product and bit-serial restoring divide. Uses bajc_pkg.
module bajc_alu
	import bajc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  op_t                op,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [31:0] res
);

	localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QMIN = 32'sh8000_0000;

	logic               done_q;
	logic               mul_q;
	logic               div_q;
	logic [5:0]         cnt_q;
	logic signed [63:0] prod_s1;
	logic [31:0]        rem_q;
	logic [31:0]        dvs_q;
	logic [47:0]        quo_q;
	logic               neg_q;
	logic signed [31:0] res_q;

	logic [32:0] rem_sh;
	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic signed [31:0] neg_b;
	logic signed [31:0] clamp1;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31])
			r = s[32] ? QMIN : QMAX;
		else
			r = s[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] mul_sat(input logic signed [63:0] p);
		logic signed [63:0] adj;
		logic signed [47:0] sh;
		logic signed [31:0] r;
		adj = p + (p[63] ? 64'sd65535 : 64'sd0);
		sh = adj[63:16];
		if (sh > 48'sh0000_7FFF_FFFF)
			r = QMAX;
		else if (sh < -48'sh0000_8000_0000)
			r = QMIN;
		else
			r = sh[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] div_sat(input logic [47:0] q, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if (q > 48'h0000_8000_0000)
				r = QMIN;
			else
				r = -q[31:0];
		end else begin
			if (q > 48'h0000_7FFF_FFFF)
				r = QMAX;
			else
				r = q[31:0];
		end
		return r;
	endfunction

	assign mag_a  = a[31] ? -a : a;
	assign mag_b  = b[31] ? -b : b;
	assign neg_b  = -b;
	assign clamp1 = (a >= b) ? b : a;
	assign rem_sh = {rem_q, quo_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				case (op)
					OP_MUL: begin
						mul_q  <= 1'b1;
						done_q <= 1'b0;
					end
					OP_DIV: begin
						if (b == 32'sd0) begin
							done_q <= 1'b1;
						end else begin
							div_q  <= 1'b1;
							cnt_q  <= 6'd48;
							done_q <= 1'b0;
						end
					end
					default: done_q <= 1'b1;
				endcase
			end else if (mul_q) begin
				mul_q  <= 1'b0;
				done_q <= 1'b1;
			end else if (div_q) begin
				if (cnt_q == 6'd0) begin
					div_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q  <= cnt_q - 6'd1;
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			case (op)
				OP_ADD: res_q <= sat33({a[31], a} + {b[31], b});
				OP_SUB: res_q <= sat33({a[31], a} - {b[31], b});
				OP_MOV: res_q <= a;
				OP_CLAMP: res_q <= (clamp1 <= neg_b) ? neg_b : clamp1;
				OP_MUL: prod_s1 <= a * b;
				OP_DIV: begin
					if (b == 32'sd0)
						res_q <= (a > 32'sd0) ? QMAX : ((a < 32'sd0) ? QMIN : 32'sd0);
					rem_q <= '0;
					dvs_q <= mag_b;
					quo_q <= {mag_a, 16'h0000};
					neg_q <= a[31] ^ b[31];
				end
				default: res_q <= a;
			endcase
		end else if (mul_q) begin
			res_q <= mul_sat(prod_s1);
		end else if (div_q) begin
			if (cnt_q == 6'd0) begin
				res_q <= div_sat(quo_q, neg_q);
			end else if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= 32'(rem_sh - {1'b0, dvs_q});
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[hw/rtl/bajc_datapath.sv]
// Datapath: slot memory with two registered read ports, input and output
// registers, and the arithmetic unit. Uses bajc_pkg and bajc_alu.
module bajc_datapath
	import bajc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] measured_pos,
	input  logic [31:0] measured_vel,
	input  logic [15:0] step_period,
	input  logic [31:0] desired_acc,
	input  logic [31:0] desired_vel,
	input  logic [31:0] desired_pos,
	output logic [31:0] torque_now,
	output logic [31:0] torque_before,
	output logic [31:0] proxy_pos_out,
	output logic [31:0] proxy_vel_out,
	output logic [31:0] proxy_acc_out
);

	logic [31:0] mem_q [64];
	logic [63:0] vld_q;
	logic [31:0] da_q, db_q;
	logic        va_q, vb_q;
	slot_t       aa_q, ab_q;
	logic [31:0] in_q [6];
	slot_t       dst_q;

	logic [31:0] st_tau_q, st_ptau_q, st_qx_q, st_ux_q, st_ax_q;
	logic [31:0] o_tau_q, o_ptau_q, o_qx_q, o_ux_q, o_ax_q;

	logic        we;
	slot_t       wa;
	logic [31:0] wd;
	logic        alu_done;
	logic signed [31:0] alu_res;
	logic [31:0] opa, opb;

	assign opa = va_q ? da_q : rst_val(aa_q);
	assign opb = vb_q ? db_q : rst_val(ab_q);

	bajc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (cmd.op),
		.a      (opa),
		.b      (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_comb begin
		we = 1'b0;
		wa = S_X1;
		wd = '0;
		if (alu_done) begin
			we = 1'b1;
			wa = dst_q;
			wd = alu_res;
		end else if (cmd.ld_en) begin
			we = 1'b1;
			wa = {3'b000, cmd.ld_k};
			wd = in_q[cmd.ld_k];
		end else if (cfg_we && !cfg_index[3]) begin
			we = 1'b1;
			wa = {CFG_BASE_HI, cfg_index[2:0]};
			wd = {1'b0, cfg_data[30:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (we)
			vld_q[wa] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		if (cmd.rd_en) begin
			da_q <= mem_q[cmd.rd_a];
			db_q <= mem_q[cmd.rd_b];
			va_q <= vld_q[cmd.rd_a];
			vb_q <= vld_q[cmd.rd_b];
			aa_q <= cmd.rd_a;
			ab_q <= cmd.rd_b;
		end
		if (cmd.start)
			dst_q <= cmd.dst;
		if (cmd.capture) begin
			in_q[0] <= measured_pos;
			in_q[1] <= measured_vel;
			in_q[2] <= {16'h0000, step_period};
			in_q[3] <= desired_acc;
			in_q[4] <= desired_vel;
			in_q[5] <= desired_pos;
		end
		if (alu_done) begin
			case (dst_q)
				S_TAU:   st_tau_q  <= alu_res;
				S_PTAU:  st_ptau_q <= alu_res;
				S_QX:    st_qx_q   <= alu_res;
				S_UX:    st_ux_q   <= alu_res;
				S_AX:    st_ax_q   <= alu_res;
				default: ;
			endcase
		end
		if (cmd.publish) begin
			o_tau_q  <= st_tau_q;
			o_ptau_q <= st_ptau_q;
			o_qx_q   <= st_qx_q;
			o_ux_q   <= st_ux_q;
			o_ax_q   <= st_ax_q;
		end
	end

	assign status.done   = alu_done;
	assign torque_now    = o_tau_q;
	assign torque_before = o_ptau_q;
	assign proxy_pos_out = o_qx_q;
	assign proxy_vel_out = o_ux_q;
	assign proxy_acc_out = o_ax_q;

endmodule

[hw/rtl/bajc_ctrl.sv]
// Sequencer: loads a transaction into the slot memory, steps the microprogram
// and hands the result to the output register. Uses bajc_pkg.
module bajc_ctrl
	import bajc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output logic    cfg_ready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_ISSUE = 6'b001000,
		ST_WAIT  = 6'b010000,
		ST_PUB   = 6'b100000
	} state_t;

	state_t     state_q;
	logic [5:0] pc_q;
	logic [2:0] k_q;
	logic       seeded_q;
	logic       out_valid_q;
	instr_t     ins;
	logic       skip;
	logic       pub_fire;

	assign ins      = prog(pc_q);
	assign skip     = ins.seed && seeded_q;
	assign pub_fire = (state_q == ST_PUB) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			k_q         <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pub_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						k_q     <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (k_q == IN_LAST) begin
						pc_q    <= '0;
						state_q <= ST_FETCH;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_FETCH: begin
					if (skip)
						pc_q <= pc_q + 6'd1;
					else
						state_q <= ST_ISSUE;
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (status.done) begin
						if (pc_q == PROG_LAST) begin
							state_q <= ST_PUB;
						end else begin
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_PUB: begin
					if (pub_fire) begin
						seeded_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.ld_en   = (state_q == ST_LOAD);
		cmd.ld_k    = k_q;
		cmd.rd_en   = (state_q == ST_FETCH) && !skip;
		cmd.rd_a    = ins.a;
		cmd.rd_b    = ins.b;
		cmd.start   = (state_q == ST_ISSUE);
		cmd.op      = ins.op;
		cmd.dst     = ins.dst;
		cmd.publish = pub_fire;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
